FILE: src/rwtl_pkg.sv
package rwtl_pkg;

   // Field widths; data values signed Q16.16, caps unsigned Q15.16
   localparam int DATA_W    = 32;
   localparam int CAP_W     = 31;
   localparam int Q_FRAC    = 16;

   // One quotient bit per divider stage; the quotient magnitude below saturation fits CAP_W
   localparam int DIV_STEPS = CAP_W;

   // Saturation limits of the acceleration
   localparam logic [DATA_W-1:0] ACC_MAX = {1'b0, {(DATA_W-1){1'b1}}};
   localparam logic [DATA_W-1:0] ACC_MIN = {1'b1, {(DATA_W-1){1'b0}}};

   // Payload of one divider stage
   typedef struct packed {
      logic              valid;
      logic [DATA_W-1:0] motor;
      logic              limited;
      logic              neg;
      logic              ovf;
      logic              inert_pos;
      logic [CAP_W-1:0]  divisor;
      logic [CAP_W-1:0]  rem;
      logic [CAP_W-1:0]  num;
   } div_stage_type;

endpackage

FILE: src/reaction_wheel_torque_limiter.sv
// Channel   Ports                               Direction  Transfer
// --------  ----------------------------------  ---------  --------------------------------
// request   start, busy, req_*                  in         edge with start high, busy low
// response  rsp_strobe, rsp_*                   out        every edge with rsp_strobe high
//
// One axis item enters per clock while reset is low.
// Each result passes the restoring divider: 31 stages, one quotient bit each,
// behind four stages of input capture, clamping, speed limiting and setup.
// Synchronous reset empties the pipeline; busy is high only while reset is held.
// The receiver cannot stall, so the pipeline always advances and never drops items.
module reaction_wheel_torque_limiter (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic signed [rwtl_pkg::DATA_W-1:0]  req_requested_torque,
   input  logic signed [rwtl_pkg::DATA_W-1:0]  req_wheel_rate,
   input  logic signed [rwtl_pkg::DATA_W-1:0]  req_inertia,
   input  logic        [rwtl_pkg::CAP_W-1:0]   req_torque_cap,
   input  logic        [rwtl_pkg::CAP_W-1:0]   req_rate_cap,
   output logic                                rsp_strobe,
   output logic signed [rwtl_pkg::DATA_W-1:0]  rsp_applied_torque,
   output logic signed [rwtl_pkg::DATA_W-1:0]  rsp_motor_torque,
   output logic signed [rwtl_pkg::DATA_W-1:0]  rsp_acceleration,
   output logic                                rsp_rate_limited
);
   import rwtl_pkg::*;

   localparam int SH = CAP_W - Q_FRAC;   // initial remainder comes from mag >> SH

   // Stage 0: input capture
   logic                     s0_valid_ff;
   logic signed [DATA_W-1:0] s0_req_ff, s0_rate_ff, s0_inert_ff;
   logic        [CAP_W-1:0]  s0_tcap_ff, s0_rcap_ff;

   // Stage 1: torque clamp and speed flags
   logic                     s1_valid_ff;
   logic signed [DATA_W-1:0] s1_applied_ff, s1_applied_in;
   logic signed [DATA_W-1:0] s1_inert_ff;
   logic                     s1_rate_hi_ff, s1_rate_hi_in;
   logic                     s1_rate_lo_ff, s1_rate_lo_in;

   // Stage 2: motor torque and speed limit
   logic                     s2_valid_ff;
   logic signed [DATA_W-1:0] s2_motor_ff, s2_motor_in;
   logic                     s2_limited_ff, s2_limited_in;
   logic signed [DATA_W-1:0] s2_inert_ff;

   // Divider stages; entry 0 is the setup register
   div_stage_type stage_ff [DIV_STEPS+1];
   div_stage_type setup_in;

   // Output register
   logic                     rsp_strobe_ff;
   logic signed [DATA_W-1:0] rsp_applied_ff, rsp_motor_ff, rsp_accel_ff;
   logic                     rsp_limited_ff;
   logic signed [DATA_W-1:0] accel_in;
   logic        [DATA_W-1:0] quot_x;

   assign busy = reset;

   // Capture the request on transfer
   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff <= 1'b0;
      end else begin
         s0_valid_ff <= start && !busy;
      end
      s0_req_ff   <= req_requested_torque;
      s0_rate_ff  <= req_wheel_rate;
      s0_inert_ff <= req_inertia;
      s0_tcap_ff  <= req_torque_cap;
      s0_rcap_ff  <= req_rate_cap;
   end

   // Clamp the requested torque and compare the wheel speed with its limits
   always_comb begin
      logic signed [DATA_W:0] req_x, tcap_x, rate_x, rcap_x, ntcap_x;
      req_x   = {s0_req_ff[DATA_W-1], s0_req_ff};
      rate_x  = {s0_rate_ff[DATA_W-1], s0_rate_ff};
      tcap_x  = {2'b00, s0_tcap_ff};
      rcap_x  = {2'b00, s0_rcap_ff};
      ntcap_x = -tcap_x;
      if (req_x > tcap_x) begin
         s1_applied_in = tcap_x[DATA_W-1:0];
      end else if (req_x < ntcap_x) begin
         s1_applied_in = ntcap_x[DATA_W-1:0];
      end else begin
         s1_applied_in = s0_req_ff;
      end
      s1_rate_hi_in = rate_x >= rcap_x;
      s1_rate_lo_in = rate_x <= -rcap_x;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s0_valid_ff;
      end
      s1_applied_ff <= s1_applied_in;
      s1_rate_hi_ff <= s1_rate_hi_in;
      s1_rate_lo_ff <= s1_rate_lo_in;
      s1_inert_ff   <= s0_inert_ff;
   end

   // Negate into motor torque and drop it at a speed limit
   always_comb begin
      logic signed [DATA_W-1:0] motor;
      logic                     block;
      motor = -s1_applied_ff;
      block = (s1_rate_hi_ff && motor > 0) || (s1_rate_lo_ff && motor < 0);
      s2_limited_in = block;
      s2_motor_in   = block ? '0 : motor;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else begin
         s2_valid_ff <= s1_valid_ff;
      end
      s2_motor_ff   <= s2_motor_in;
      s2_limited_ff <= s2_limited_in;
      s2_inert_ff   <= s1_inert_ff;
   end

   // Set up the magnitude division of motor * 2^16 by inertia
   always_comb begin
      logic signed [DATA_W-1:0] abs_m;
      logic [CAP_W-1:0]         mag;
      logic [CAP_W+SH-1:0]      mag_x, lim_x;
      abs_m = s2_motor_ff[DATA_W-1] ? -s2_motor_ff : s2_motor_ff;
      mag   = abs_m[CAP_W-1:0];
      mag_x = {{SH{1'b0}}, mag};
      lim_x = {s2_inert_ff[CAP_W-1:0], {SH{1'b0}}};
      setup_in.valid     = s2_valid_ff;
      setup_in.motor     = s2_motor_ff;
      setup_in.limited   = s2_limited_ff;
      setup_in.neg       = s2_motor_ff[DATA_W-1];
      setup_in.inert_pos = !s2_inert_ff[DATA_W-1] && (s2_inert_ff != '0);
      setup_in.ovf       = mag_x >= lim_x;
      setup_in.divisor   = s2_inert_ff[CAP_W-1:0];
      setup_in.rem       = {{SH{1'b0}}, mag[CAP_W-1:SH]};
      setup_in.num       = {mag[SH-1:0], {Q_FRAC{1'b0}}};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_ff[0].valid <= 1'b0;
      end else begin
         stage_ff[0] <= setup_in;
      end
   end

   // Restoring divider: one quotient bit per stage, shifted into num
   for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
      div_stage_type step_in;

      always_comb begin
         logic [CAP_W:0]   trial;
         logic [CAP_W+1:0] diff;
         trial = {stage_ff[k].rem, stage_ff[k].num[CAP_W-1]};
         diff  = {1'b0, trial} - {2'b00, stage_ff[k].divisor};
         step_in = stage_ff[k];
         if (!diff[CAP_W+1]) begin
            step_in.rem = diff[CAP_W-1:0];
         end else begin
            step_in.rem = trial[CAP_W-1:0];
         end
         step_in.num = {stage_ff[k].num[CAP_W-2:0], !diff[CAP_W+1]};
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            stage_ff[k+1].valid <= 1'b0;
         end else begin
            stage_ff[k+1] <= step_in;
         end
      end
   end

   // Apply sign and saturation to the quotient; zero when inertia is not positive
   always_comb begin
      quot_x = {1'b0, stage_ff[DIV_STEPS].num};
      if (!stage_ff[DIV_STEPS].inert_pos) begin
         accel_in = '0;
      end else if (stage_ff[DIV_STEPS].ovf) begin
         accel_in = stage_ff[DIV_STEPS].neg ? ACC_MIN : ACC_MAX;
      end else begin
         accel_in = stage_ff[DIV_STEPS].neg ? -quot_x : quot_x;
      end
   end

   // Register the result for one strobe cycle
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= stage_ff[DIV_STEPS].valid;
      end
      rsp_motor_ff   <= stage_ff[DIV_STEPS].motor;
      rsp_applied_ff <= -stage_ff[DIV_STEPS].motor;
      rsp_accel_ff   <= accel_in;
      rsp_limited_ff <= stage_ff[DIV_STEPS].limited;
   end

   assign rsp_strobe         = rsp_strobe_ff;
   assign rsp_applied_torque = rsp_applied_ff;
   assign rsp_motor_torque   = rsp_motor_ff;
   assign rsp_acceleration   = rsp_accel_ff;
   assign rsp_rate_limited   = rsp_limited_ff;

endmodule

FILE: sim/tb_reaction_wheel_torque_limiter.sv
`timescale 1ns / 1ps

module tb_reaction_wheel_torque_limiter;
   import rwtl_pkg::*;

   localparam int RANDOM_AXES  = 1930;
   localparam int CALM_FIRST   = 700;
   localparam int CALM_LAST    = 1100;
   localparam int DRAIN_CYCLES = 40;
   localparam int CYCLE_LIMIT  = 200000;
   localparam longint ACCEL_HI = 64'sd2147483647;
   localparam longint ACCEL_LO = -64'sd2147483648;

   typedef struct packed {
      logic signed [DATA_W-1:0] applied;
      logic signed [DATA_W-1:0] motor;
      logic signed [DATA_W-1:0] accel;
      logic                     limited;
   } axis_result_type;

   typedef struct {
      logic [DATA_W-1:0] torque;
      logic [DATA_W-1:0] rate;
      logic [DATA_W-1:0] inertia;
      logic [CAP_W-1:0]  torque_cap;
      logic [CAP_W-1:0]  rate_cap;
      bit                fixed;
      axis_result_type   result;
   } axis_row_type;

   logic                     clock;
   logic                     reset;
   logic                     start;
   logic                     busy;
   logic signed [DATA_W-1:0] req_requested_torque;
   logic signed [DATA_W-1:0] req_wheel_rate;
   logic signed [DATA_W-1:0] req_inertia;
   logic        [CAP_W-1:0]  req_torque_cap;
   logic        [CAP_W-1:0]  req_rate_cap;
   logic                     rsp_strobe;
   logic signed [DATA_W-1:0] rsp_applied_torque;
   logic signed [DATA_W-1:0] rsp_motor_torque;
   logic signed [DATA_W-1:0] rsp_acceleration;
   logic                     rsp_rate_limited;

   // Hand-computed result that travels with a directed row
   bit                       row_fixed;
   axis_result_type          row_result;

   axis_result_type          pending_results[$];
   int                       fail_count;
   int                       cycle_count;

   reaction_wheel_torque_limiter u_dut (
      .clock                (clock),
      .reset                (reset),
      .start                (start),
      .busy                 (busy),
      .req_requested_torque (req_requested_torque),
      .req_wheel_rate       (req_wheel_rate),
      .req_inertia          (req_inertia),
      .req_torque_cap       (req_torque_cap),
      .req_rate_cap         (req_rate_cap),
      .rsp_strobe           (rsp_strobe),
      .rsp_applied_torque   (rsp_applied_torque),
      .rsp_motor_torque     (rsp_motor_torque),
      .rsp_acceleration     (rsp_acceleration),
      .rsp_rate_limited     (rsp_rate_limited)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Clamp torque, apply the speed limits, then divide by inertia with saturation
   function automatic axis_result_type limit_axis(input logic signed [DATA_W-1:0] torque,
                                                  input logic signed [DATA_W-1:0] rate,
                                                  input logic signed [DATA_W-1:0] inertia,
                                                  input logic [CAP_W-1:0] torque_cap,
                                                  input logic [CAP_W-1:0] rate_cap);
      longint          rq;
      longint          rt;
      longint          inr;
      longint          tc;
      longint          rc;
      longint          applied;
      longint          motor;
      longint          accel;
      axis_result_type res;
      rq  = torque;
      rt  = rate;
      inr = inertia;
      tc  = torque_cap;
      rc  = rate_cap;
      res.limited = 1'b0;
      applied = rq;
      if (applied > tc) begin
         applied = tc;
      end else if (applied < -tc) begin
         applied = -tc;
      end
      motor = -applied;
      if (rt >= rc && motor > 0) begin
         motor = 0;
         res.limited = 1'b1;
      end
      if (rt <= -rc && motor < 0) begin
         motor = 0;
         res.limited = 1'b1;
      end
      accel = 0;
      if (inr > 0) begin
         accel = (motor * (64'sd1 <<< Q_FRAC)) / inr;
         if (accel > ACCEL_HI) begin
            accel = ACCEL_HI;
         end else if (accel < ACCEL_LO) begin
            accel = ACCEL_LO;
         end
      end
      res.applied = DATA_W'(-motor);
      res.motor   = DATA_W'(motor);
      res.accel   = DATA_W'(accel);
      return res;
   endfunction

   // Signed word biased toward the extremes and small magnitudes
   function automatic logic [DATA_W-1:0] pick_word();
      case ($urandom_range(7))
         0: begin
            case ($urandom_range(5))
               0:       return '0;
               1:       return 32'h0000_0001;
               2:       return '1;
               3:       return 32'h7fff_ffff;
               4:       return 32'h8000_0000;
               default: return 32'h0001_0000;
            endcase
         end
         1, 2: return DATA_W'(int'($urandom_range(0, 2**21)) - 2**20);
         default: return $urandom;
      endcase
   endfunction

   function automatic logic [CAP_W-1:0] pick_cap();
      case ($urandom_range(7))
         0: begin
            case ($urandom_range(3))
               0:       return '0;
               1:       return 31'h0000_0001;
               2:       return '1;
               default: return 31'h0001_0000;
            endcase
         end
         1, 2: return CAP_W'($urandom_range(0, 2**21));
         default: return CAP_W'($urandom);
      endcase
   endfunction

   // Present one axis and hold it until the block takes the transfer
   task automatic send_axis(input axis_row_type row, input bit may_idle);
      if (may_idle) begin
         while ($urandom_range(99) < 38) begin
            start <= 1'b0;
            @(posedge clock);
         end
      end
      start                <= 1'b1;
      req_requested_torque <= row.torque;
      req_wheel_rate       <= row.rate;
      req_inertia          <= row.inertia;
      req_torque_cap       <= row.torque_cap;
      req_rate_cap         <= row.rate_cap;
      row_fixed            <= row.fixed;
      row_result           <= row.result;
      @(posedge clock);
      while (busy) begin
         @(posedge clock);
      end
   endtask

   // Stimulus: directed rows, then random axes, then drain
   initial begin
      axis_row_type axis_rows[$];
      axis_row_type row;
      int           delta;
      start                = 1'b0;
      reset                = 1'b1;
      req_requested_torque = '0;
      req_wheel_rate       = '0;
      req_inertia          = '0;
      req_torque_cap       = '0;
      req_rate_cap         = '0;
      row_fixed            = 1'b0;
      row_result           = '0;

      // All zero, extremes of torque, zero caps
      axis_rows.push_back('{32'h0, 32'h0, 32'h0, 31'h0, 31'h0, 1'b1,
                            '{32'h0, 32'h0, 32'h0, 1'b0}});
      axis_rows.push_back('{32'h7fffffff, 32'h0, 32'h00010000, 31'h7fffffff, 31'h7fffffff,
                            1'b1, '{32'h7fffffff, 32'h80000001, 32'h80000001, 1'b0}});
      axis_rows.push_back('{32'h80000000, 32'h0, 32'h00000001, 31'h7fffffff, 31'h7fffffff,
                            1'b1, '{32'h80000001, 32'h7fffffff, 32'h7fffffff, 1'b0}});
      axis_rows.push_back('{32'h00003039, 32'h7fffffff, 32'h00010000, 31'h0, 31'h0, 1'b1,
                            '{32'h0, 32'h0, 32'h0, 1'b0}});
      axis_rows.push_back('{32'h00010000, 32'h0, 32'h00010000, 31'h00010000, 31'h0, 1'b1,
                            '{32'h0, 32'h0, 32'h0, 1'b1}});
      axis_rows.push_back('{32'hffff0000, 32'h0, 32'h00010000, 31'h00010000, 31'h0, 1'b1,
                            '{32'h0, 32'h0, 32'h0, 1'b1}});
      // Wheel exactly at its speed limits, either sign of motor torque
      axis_rows.push_back('{32'hffff0000, 32'h00100000, 32'h00010000, 31'h7fffffff,
                            31'h00100000, 1'b1, '{32'h0, 32'h0, 32'h0, 1'b1}});
      axis_rows.push_back('{32'h00010000, 32'h00100000, 32'h00010000, 31'h7fffffff,
                            31'h00100000, 1'b1,
                            '{32'h00010000, 32'hffff0000, 32'hffff0000, 1'b0}});
      axis_rows.push_back('{32'h00010000, 32'hfff00000, 32'h00010000, 31'h7fffffff,
                            31'h00100000, 1'b1, '{32'h0, 32'h0, 32'h0, 1'b1}});
      // Non-positive inertia
      axis_rows.push_back('{32'h00010000, 32'h0, 32'hffffffff, 31'h7fffffff, 31'h7fffffff,
                            1'b1, '{32'h00010000, 32'hffff0000, 32'h0, 1'b0}});
      axis_rows.push_back('{32'h00010000, 32'h0, 32'h0, 31'h7fffffff, 31'h7fffffff,
                            1'b1, '{32'h00010000, 32'hffff0000, 32'h0, 1'b0}});
      axis_rows.push_back('{32'h00010000, 32'h0, 32'h80000000, 31'h7fffffff, 31'h7fffffff,
                            1'b1, '{32'h00010000, 32'hffff0000, 32'h0, 1'b0}});
      // Division corners and clamp boundaries
      axis_rows.push_back('{32'h00010000, 32'h0, 32'h7fffffff, 31'h7fffffff, 31'h7fffffff,
                            1'b0, '0});
      axis_rows.push_back('{32'h00000001, 32'h0, 32'h00000001, 31'h7fffffff, 31'h7fffffff,
                            1'b0, '0});
      axis_rows.push_back('{32'h00000001, 32'h0, 32'h00000003, 31'h7fffffff, 31'h7fffffff,
                            1'b0, '0});
      axis_rows.push_back('{32'hffffffff, 32'h0, 32'h00000003, 31'h7fffffff, 31'h7fffffff,
                            1'b0, '0});
      axis_rows.push_back('{32'h00020000, 32'h0, 32'h00010000, 31'h00020000, 31'h7fffffff,
                            1'b0, '0});
      axis_rows.push_back('{32'hfffe0000, 32'h0, 32'h00010000, 31'h00020000, 31'h7fffffff,
                            1'b0, '0});
      axis_rows.push_back('{32'h00020001, 32'h0, 32'h00010000, 31'h00020000, 31'h7fffffff,
                            1'b0, '0});
      axis_rows.push_back('{32'h80000000, 32'h0, 32'h00000100, 31'h00001000, 31'h7fffffff,
                            1'b0, '0});
      // Extreme wheel rates against the widest speed limit, and one just below a narrower one
      axis_rows.push_back('{32'hffffffff, 32'h7fffffff, 32'h00010000, 31'h7fffffff,
                            31'h7fffffff, 1'b0, '0});
      axis_rows.push_back('{32'h00000001, 32'h80000000, 32'h00010000, 31'h7fffffff,
                            31'h7fffffff, 1'b0, '0});
      axis_rows.push_back('{32'hffffffff, 32'h000fffff, 32'h00010000, 31'h7fffffff,
                            31'h00100000, 1'b0, '0});
      axis_rows.push_back('{32'hffffffff, 32'hffffffff, 32'hffffffff, 31'h7fffffff,
                            31'h7fffffff, 1'b0, '0});

      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (axis_rows[i]) begin
         send_axis(axis_rows[i], 1'b1);
      end

      for (int n = 0; n < RANDOM_AXES; n++) begin
         row.torque     = pick_word();
         row.rate       = pick_word();
         row.inertia    = pick_word();
         row.torque_cap = pick_cap();
         row.rate_cap   = pick_cap();
         row.fixed      = 1'b0;
         row.result     = '0;
         delta          = int'($urandom_range(0, 4)) - 2;
         case ($urandom_range(9))
            // Wheel speed right around one of its limits
            3, 4, 5: begin
               if ($urandom_range(1)) begin
                  row.rate = DATA_W'(int'({1'b0, row.rate_cap}) + delta);
               end else begin
                  row.rate = DATA_W'(-int'({1'b0, row.rate_cap}) + delta);
               end
            end
            // Requested torque right around the torque limit
            6, 7: begin
               if ($urandom_range(1)) begin
                  row.torque = DATA_W'(int'({1'b0, row.torque_cap}) + delta);
               end else begin
                  row.torque = DATA_W'(-int'({1'b0, row.torque_cap}) + delta);
               end
            end
            // Small positive inertia drives the quotient toward saturation
            8, 9: begin
               row.inertia = DATA_W'($urandom_range(1, 2**17));
            end
            default: begin
            end
         endcase
         send_axis(row, !(n >= CALM_FIRST && n < CALM_LAST));
      end
      start <= 1'b0;

      while (pending_results.size() != 0) begin
         @(posedge clock);
      end
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

   // Predict on each request transfer, check each response transfer
   always @(posedge clock) begin
      axis_result_type want;
      if (!reset) begin
         if (rsp_strobe) begin
            if (pending_results.size() == 0) begin
               $error("unexpected result: applied_torque %0d", rsp_applied_torque);
               fail_count++;
            end else begin
               want = pending_results.pop_front();
               if (rsp_applied_torque !== want.applied) begin
                  $error("applied_torque: expected %0d, actual %0d",
                         want.applied, rsp_applied_torque);
                  fail_count++;
               end
               if (rsp_motor_torque !== want.motor) begin
                  $error("motor_torque: expected %0d, actual %0d",
                         want.motor, rsp_motor_torque);
                  fail_count++;
               end
               if (rsp_acceleration !== want.accel) begin
                  $error("acceleration: expected %0d, actual %0d",
                         want.accel, rsp_acceleration);
                  fail_count++;
               end
               if (rsp_rate_limited !== want.limited) begin
                  $error("rate_limited: expected %0d, actual %0d",
                         want.limited, rsp_rate_limited);
                  fail_count++;
               end
            end
         end
         if (start && !busy) begin
            if (row_fixed) begin
               pending_results.push_back(row_result);
            end else begin
               pending_results.push_back(limit_axis(req_requested_torque, req_wheel_rate,
                                                    req_inertia, req_torque_cap,
                                                    req_rate_cap));
            end
         end
      end
   end

   // Bound the run
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("status: fail");
         $finish;
      end
   end

endmodule
